// File: rtl/button_press_gesture_classifier_core_assert.svh
// assertion macros used by the port-level checker
`ifndef BUTTON_PRESS_GESTURE_CLASSIFIER_CORE_ASSERT_SVH
`define BUTTON_PRESS_GESTURE_CLASSIFIER_CORE_ASSERT_SVH

// concurrent check that is switched off while reset is high
`define BPGC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bpgc check failed");

// concurrent check that also holds across reset
`define BPGC_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("bpgc check failed");

`endif

// File: rtl/bpgc_pkg.sv
// shared constants and types of the button press gesture classifier
package bpgc_pkg;

   localparam int unsigned POLL_BITS      = 10;
   localparam int unsigned LONG_BITS      = 16;
   localparam int unsigned HOLD_BITS_DEF  = 16;
   localparam int unsigned CSR_INDEX_BITS = 2;
   localparam int unsigned CSR_DATA_BITS  = 16;
   localparam int unsigned REQ_DATA_BITS  = 8;
   localparam int unsigned RSP_DATA_BITS  = 8;

   localparam logic [POLL_BITS-1:0] POLL_PERIOD_RESET = 10'd50;
   localparam logic [LONG_BITS-1:0] LONG_PRESS_RESET  = 16'd1500;
   localparam logic [POLL_BITS-1:0] POLL_MAX          = '1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_POLL_PERIOD = 2'd0,
      CSR_LONG_PRESS  = 2'd1
   } csr_index_type;

   // one decoded input item
   typedef struct packed {
      logic ack_release;
      logic ack_long;
      logic ack_short;
      logic button_down;
   } req_item_type;

   // one result item
   typedef struct packed {
      logic button_held;
      logic release_pending;
      logic long_pending;
      logic short_pending;
   } rsp_item_type;

endpackage

// File: rtl/button_press_gesture_classifier_core.sv
// top level of the button press gesture classifier
//
// usage:
//  - req channel: one item per millisecond tick, tdata carries the raw button
//    level and the three acknowledge bits from software
//  - rsp channel: one item per accepted tick with the three sticky event
//    flags and the level seen at the last poll
//  - csr channel: register writes (poll period, long-press time), always
//    ready; write only while no tick is in flight
// latency: the result of a tick is on rsp one cycle after it is accepted
// throughput: one tick per cycle; the state update and the result are formed
//   in one pass of short counter and compare logic into the result register
// stall: while a result waits, req_tready stays high if rsp_tready is high,
//   so a new tick enters in the same cycle the old result leaves; with
//   rsp_tready low the result holds and req_tready drops
// reset: synchronous, active high; counters, level and flags clear, the
//   registers return to a 50 ms poll period and a 1500 ms long-press time,
//   and the rsp register empties
module button_press_gesture_classifier_core #(
   parameter int unsigned HOLD_BITS = bpgc_pkg::HOLD_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // req tdata: [0] button_down, [1] ack_short, [2] ack_long, [3] ack_release
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [bpgc_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // rsp tdata: [0] short_pending, [1] long_pending, [2] release_pending,
   //            [3] button_held
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [bpgc_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   // csr write channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bpgc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [bpgc_pkg::CSR_DATA_BITS-1:0]   csr_data
);
   import bpgc_pkg::*;

   // widest of the hold counter and the long-press register, for the compare
   localparam int unsigned CMP_BITS = (HOLD_BITS > LONG_BITS) ? HOLD_BITS : LONG_BITS;
   localparam logic [HOLD_BITS-1:0] HOLD_MAX = '1;

   // configuration
   logic [POLL_BITS-1:0] poll_period_ff;
   logic [LONG_BITS-1:0] long_press_ff;

   // tick state
   logic [POLL_BITS-1:0] poll_elapsed_ff, poll_elapsed_in;
   logic [HOLD_BITS-1:0] hold_elapsed_ff, hold_elapsed_in;
   logic                 last_level_ff,   last_level_in;
   logic                 long_done_ff,    long_done_in;
   logic                 short_flag_ff,   short_flag_in;
   logic                 long_flag_ff,    long_flag_in;
   logic                 release_flag_ff, release_flag_in;

   // result register
   logic                 rsp_valid_ff,    rsp_valid_in;
   rsp_item_type         rsp_item_ff,     rsp_item_in;

   req_item_type         req_item;
   logic                 req_accept;
   logic                 poll_now;
   logic [POLL_BITS-1:0] poll_step;
   logic [HOLD_BITS-1:0] hold_step;
   logic                 short_set, long_set, release_set;

   assign csr_ready  = 1'b1;
   assign req_item   = req_item_type'(req_tdata[$bits(req_item_type)-1:0]);
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         poll_period_ff <= POLL_PERIOD_RESET;
         long_press_ff  <= LONG_PRESS_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_POLL_PERIOD: poll_period_ff <= csr_data[POLL_BITS-1:0];
            CSR_LONG_PRESS:  long_press_ff  <= csr_data[LONG_BITS-1:0];
            default: ; // writes beyond the register list are dropped
         endcase
      end
   end

   // one tick: advance the saturating counters, poll, classify the edge
   always_comb begin
      poll_step = (poll_elapsed_ff < POLL_MAX) ? poll_elapsed_ff + 1'b1 : poll_elapsed_ff;
      hold_step = (hold_elapsed_ff < HOLD_MAX) ? hold_elapsed_ff + 1'b1 : hold_elapsed_ff;
      poll_now  = (poll_step >= poll_period_ff);

      poll_elapsed_in = poll_now ? '0 : poll_step;
      hold_elapsed_in = hold_step;
      last_level_in   = last_level_ff;
      long_done_in    = long_done_ff;
      short_set       = 1'b0;
      long_set        = 1'b0;
      release_set     = 1'b0;

      if (poll_now) begin
         last_level_in = req_item.button_down;
         if (req_item.button_down && !last_level_ff) begin
            // press edge restarts the hold and re-arms the long detector
            hold_elapsed_in = '0;
            long_done_in    = 1'b0;
         end else if (req_item.button_down && last_level_ff) begin
            if (!long_done_ff &&
                (CMP_BITS'(hold_step) >= CMP_BITS'(long_press_ff))) begin
               long_set     = 1'b1;
               long_done_in = 1'b1;
            end
         end else if (!req_item.button_down && last_level_ff) begin
            release_set = 1'b1;
            short_set   = !long_done_ff;
         end
      end

      // flags as reported, then cleared by their acks
      rsp_item_in.short_pending   = short_flag_ff   || short_set;
      rsp_item_in.long_pending    = long_flag_ff    || long_set;
      rsp_item_in.release_pending = release_flag_ff || release_set;
      rsp_item_in.button_held     = last_level_in;

      short_flag_in   = rsp_item_in.short_pending   && !req_item.ack_short;
      long_flag_in    = rsp_item_in.long_pending    && !req_item.ack_long;
      release_flag_in = rsp_item_in.release_pending && !req_item.ack_release;
   end

   always_comb begin
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poll_elapsed_ff <= '0;
         hold_elapsed_ff <= '0;
         last_level_ff   <= 1'b0;
         long_done_ff    <= 1'b0;
         short_flag_ff   <= 1'b0;
         long_flag_ff    <= 1'b0;
         release_flag_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            poll_elapsed_ff <= poll_elapsed_in;
            hold_elapsed_ff <= hold_elapsed_in;
            last_level_ff   <= last_level_in;
            long_done_ff    <= long_done_in;
            short_flag_ff   <= short_flag_in;
            long_flag_ff    <= long_flag_in;
            release_flag_ff <= release_flag_in;
         end
      end
   end

   // result payload needs no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'(rsp_item_ff);

endmodule

// File: rtl/bpgc_checker.sv
// port-level checks of the button press gesture classifier, bound to the top
`include "button_press_gesture_classifier_core_assert.svh"

module bpgc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [bpgc_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [bpgc_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   input logic                                csr_valid,
   input logic                                csr_ready,
   input logic [bpgc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input logic [bpgc_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import bpgc_pkg::*;

   // a stalled result holds its value
   `BPGC_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))

   // every accepted tick shows its result in the next cycle
   `BPGC_ASSERT(a_rsp_follows, clock, reset, req_tvalid && req_tready |=> rsp_tvalid)

   // input is held off only by a stalled result
   `BPGC_ASSERT(a_ready_rule, clock, reset, req_tready == (!rsp_tvalid || rsp_tready))

   // the result register is empty after reset
   `BPGC_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid)

endmodule

bind button_press_gesture_classifier_core bpgc_checker u_bpgc_checker (.*);
